@@ rtl/cte_pkg.sv @@
// Shared constants, types and calendar tables for the calendar to epoch seconds converter.
`default_nettype none
package cte_pkg;

  localparam int unsigned YEAR_BITS_DEF = 8;
  localparam int unsigned BASE_YEAR     = 1900;
  localparam int unsigned EPOCH_YEAR    = 1970;
  localparam int unsigned EPOCH_OFS     = 70;    // EPOCH_YEAR - BASE_YEAR
  localparam int unsigned SEC_W         = 33;
  localparam int unsigned PIPE_DEPTH    = 5;

  // floor(x / 100) = (x * Q100_MUL) >> Q100_SHIFT, exact for x below 8192
  localparam int unsigned Q100_MUL      = 5243;
  localparam int unsigned Q100_SHIFT    = 19;

  // leap years in 1..1969: 492 - 19 + 4
  localparam int unsigned LEAPS_1969    = 477;

  localparam logic [3:0] MON_FEB = 4'd1;
  localparam logic [3:0] MON_DEC = 4'd11;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } hms_t;

  // days ahead of the first of a month, common year
  function automatic logic [8:0] days_before_month(input logic [3:0] mon);
    logic [8:0] d;
    case (mon)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // month length, common year
  function automatic logic [4:0] month_len(input logic [3:0] mon);
    logic [4:0] l;
    case (mon)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: l = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                   l = 5'd30;
      4'd1:                                      l = 5'd28;
      default:                                   l = 5'd0;
    endcase
    return l;
  endfunction

endpackage
`default_nettype wire

@@ rtl/cte_decode.sv @@
// Stage 1: field range checks and year-by-hundred quotients.
`default_nettype none
module cte_decode
  import cte_pkg::*;
#(
  parameter int unsigned YEAR_BITS = YEAR_BITS_DEF,
  parameter int unsigned YEAR_W    = 13
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [YEAR_BITS-1:0] yoff_i,
  input  wire logic [3:0]           month_i,
  input  wire logic [4:0]           day_i,
  input  wire hms_t                 hms_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [YEAR_W-1:0]         year_o,
  output logic [3:0]                month_o,
  output logic [4:0]                day_o,
  output hms_t                      hms_o,
  output logic [YEAR_W-7:0]         q_year_o,
  output logic [YEAR_W-7:0]         q_prev_o,
  output logic                      chk_o
);

  localparam int unsigned PROD_W = YEAR_W + 13;
  localparam int unsigned Q_W    = YEAR_W - 6;  // year / 100 < 2**YEAR_W / 64

  logic [YEAR_W-1:0] year;
  logic [YEAR_W-1:0] year_m1;
  logic [PROD_W-1:0] prod_y;
  logic [PROD_W-1:0] prod_p;
  logic              chk;
  logic              load;

  logic              v_q;
  logic [YEAR_W-1:0] year_q;
  logic [3:0]        month_q;
  logic [4:0]        day_q;
  hms_t              hms_q;
  logic [Q_W-1:0]    q_year_q;
  logic [Q_W-1:0]    q_prev_q;
  logic              chk_q;

  assign year    = YEAR_W'(BASE_YEAR) + YEAR_W'(yoff_i);
  assign year_m1 = year - YEAR_W'(1);
  assign prod_y  = PROD_W'(year) * PROD_W'(Q100_MUL);
  assign prod_p  = PROD_W'(year_m1) * PROD_W'(Q100_MUL);

  assign chk = (yoff_i >= YEAR_BITS'(EPOCH_OFS)) && (month_i <= MON_DEC) &&
               (hms_i.hour <= 5'd23) && (hms_i.minute <= 6'd59) &&
               (hms_i.second <= 6'd59);

  assign in_ready_o = !v_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      year_q   <= year;
      month_q  <= month_i;
      day_q    <= day_i;
      hms_q    <= hms_i;
      q_year_q <= prod_y[Q100_SHIFT +: Q_W];
      q_prev_q <= prod_p[Q100_SHIFT +: Q_W];
      chk_q    <= chk;
    end
  end

  assign out_valid_o = v_q;
  assign year_o      = year_q;
  assign month_o     = month_q;
  assign day_o       = day_q;
  assign hms_o       = hms_q;
  assign q_year_o    = q_year_q;
  assign q_prev_o    = q_prev_q;
  assign chk_o       = chk_q;

endmodule
`default_nettype wire

@@ rtl/cte_days.sv @@
// Stage 2: leap rule, day-of-month check and day count since the epoch.
`default_nettype none
module cte_days
  import cte_pkg::*;
#(
  parameter int unsigned YEAR_W = 13,
  parameter int unsigned DAYS_W = 18
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [YEAR_W-1:0] year_i,
  input  wire logic [3:0]        month_i,
  input  wire logic [4:0]        day_i,
  input  wire hms_t              hms_i,
  input  wire logic [YEAR_W-7:0] q_year_i,
  input  wire logic [YEAR_W-7:0] q_prev_i,
  input  wire logic              chk_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [DAYS_W-1:0]      days_o,
  output hms_t                   hms_o,
  output logic                   ok_o
);

  logic [YEAR_W-1:0] hund;
  logic [YEAR_W-1:0] year_m1;
  logic              leap;
  logic              feb_leap;
  logic [4:0]        mlen;
  logic              day_ok;
  logic [DAYS_W-1:0] span;
  logic [DAYS_W-1:0] leaps;
  logic [DAYS_W-1:0] days;
  logic              load;

  logic              v_q;
  logic [DAYS_W-1:0] days_q;
  hms_t              hms_q;
  logic              ok_q;

  // divisible by 4, and not by 100 unless by 400
  assign hund     = YEAR_W'(q_year_i) * YEAR_W'(100);
  assign leap     = (year_i[1:0] == 2'b00) &&
                    ((year_i != hund) || (q_year_i[1:0] == 2'b00));
  assign feb_leap = (month_i == MON_FEB) && leap;
  assign mlen     = month_len(month_i) + 5'(feb_leap);
  assign day_ok   = (day_i != 5'd0) && (day_i <= mlen);

  // whole years since 1970 plus leap days in 1970..year-1 (mod 2**DAYS_W)
  assign year_m1 = year_i - YEAR_W'(1);
  assign span    = DAYS_W'(year_i - YEAR_W'(EPOCH_YEAR)) * DAYS_W'(365);
  assign leaps   = DAYS_W'(year_m1 >> 2) - DAYS_W'(q_prev_i) + DAYS_W'(q_prev_i >> 2)
                 - DAYS_W'(LEAPS_1969);
  assign days    = span + leaps + DAYS_W'(days_before_month(month_i))
                 + DAYS_W'((month_i > MON_FEB) && leap) + DAYS_W'(day_i) - DAYS_W'(1);

  assign in_ready_o = !v_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      days_q <= days;
      hms_q  <= hms_i;
      ok_q   <= chk_i && day_ok;
    end
  end

  assign out_valid_o = v_q;
  assign days_o      = days_q;
  assign hms_o       = hms_q;
  assign ok_o        = ok_q;

endmodule
`default_nettype wire

@@ rtl/cte_scale.sv @@
// Stages 3 to 5: days to hours, hours to minutes, minutes to seconds.
`default_nettype none
module cte_scale
  import cte_pkg::*;
#(
  parameter int unsigned DAYS_W = 18
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [DAYS_W-1:0] days_i,
  input  wire hms_t              hms_i,
  input  wire logic              ok_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [SEC_W-1:0]       secs_o,
  output logic                   ok_o
);

  localparam int unsigned HR_W  = DAYS_W + 5;
  localparam int unsigned MIN_W = HR_W + 6;
  localparam int unsigned FUL_W = MIN_W + 6;

  logic             rdy_a, rdy_b, rdy_c;
  logic [HR_W-1:0]  hours;
  logic [MIN_W-1:0] mins;
  logic [FUL_W-1:0] secs_full;

  logic             va_q, vb_q, vc_q;
  logic [HR_W-1:0]  hours_q;
  logic [5:0]       min_a_q, sec_a_q, sec_b_q;
  logic             ok_a_q, ok_b_q, ok_c_q;
  logic [MIN_W-1:0] mins_q;
  logic [SEC_W-1:0] secs_q;

  assign rdy_c      = !vc_q || out_ready_i;
  assign rdy_b      = !vb_q || rdy_c;
  assign rdy_a      = !va_q || rdy_b;
  assign in_ready_o = rdy_a;

  assign hours     = HR_W'(days_i) * HR_W'(24) + HR_W'(hms_i.hour);
  assign mins      = MIN_W'(hours_q) * MIN_W'(60) + MIN_W'(min_a_q);
  assign secs_full = FUL_W'(mins_q) * FUL_W'(60) + FUL_W'(sec_b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= in_valid_i;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy_a) begin
      hours_q <= hours;
      min_a_q <= hms_i.minute;
      sec_a_q <= hms_i.second;
      ok_a_q  <= ok_i;
    end
    if (va_q && rdy_b) begin
      mins_q  <= mins;
      sec_b_q <= sec_a_q;
      ok_b_q  <= ok_a_q;
    end
    if (vb_q && rdy_c) begin
      secs_q <= ok_b_q ? secs_full[SEC_W-1:0] : '0;
      ok_c_q <= ok_b_q;
    end
  end

  assign out_valid_o = vc_q;
  assign secs_o      = secs_q;
  assign ok_o        = ok_c_q;

endmodule
`default_nettype wire

@@ rtl/calendar_to_epoch_seconds.sv @@
// Top level: broken-down UTC date and time to seconds since 1970-01-01.
//
// Input stream (s_axis): one transfer carries a year offset from 1900, month
// (0 = January), day of month, hour, minute and second, packed in tdata.
// Output stream (m_axis): one transfer per input, tdata holds the seconds
// since the epoch and tuser[0] is the valid flag. Any field out of range
// (year before 1970, month above 11, day zero or past month end, hour,
// minute or second too large) gives tuser[0] = 0 and tdata = 0.
//
// Five register stages: range checks and year / 100, leap rule and day
// count, then x24, x60, x60 with one constant multiply per stage. The
// result shows on m_axis once it has passed through each stage register
// in the order above. Throughput is one transfer per cycle while the
// receiver takes results; each stage holds one item and the multiply
// chain sets the depth.
//
// Reset clears all stage valid bits; no result is pending afterwards.
// When the receiver stalls, items close up into empty stages and
// s_axis_tready drops only once all five stages are full; nothing is lost
// or repeated.
`default_nettype none
module calendar_to_epoch_seconds
  import cte_pkg::*;
#(
  parameter int unsigned YEAR_BITS = YEAR_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // year_since_1900, month, day_of_month, hour, minute, second; zero pad
  input  wire logic [((YEAR_BITS+26+7)/8)*8-1:0] s_axis_tdata,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // epoch_seconds; zero pad
  output logic [((SEC_W+7)/8)*8-1:0] m_axis_tdata,
  // valid_res
  output logic [0:0] m_axis_tuser
);

  localparam int unsigned YEAR_W = $clog2(BASE_YEAR + 2**YEAR_BITS);
  localparam int unsigned DAYS_W = YEAR_BITS + 10;
  localparam int unsigned OUT_W  = ((SEC_W+7)/8)*8;
  localparam int unsigned OCC_W  = $clog2(PIPE_DEPTH + 1);

  // input field unpack
  logic [YEAR_BITS-1:0] yoff;
  logic [3:0]           month;
  logic [4:0]           day;
  hms_t                 hms_in;

  assign yoff          = s_axis_tdata[YEAR_BITS-1:0];
  assign month         = s_axis_tdata[YEAR_BITS +: 4];
  assign day           = s_axis_tdata[YEAR_BITS+4 +: 5];
  assign hms_in.hour   = s_axis_tdata[YEAR_BITS+9 +: 5];
  assign hms_in.minute = s_axis_tdata[YEAR_BITS+14 +: 6];
  assign hms_in.second = s_axis_tdata[YEAR_BITS+20 +: 6];

  // stage 1 -> 2
  logic              dec_valid, dec_ready;
  logic [YEAR_W-1:0] dec_year;
  logic [3:0]        dec_month;
  logic [4:0]        dec_day;
  hms_t              dec_hms;
  logic [YEAR_W-7:0] dec_qy, dec_qp;
  logic              dec_chk;

  // stage 2 -> 3
  logic              day_valid, day_ready;
  logic [DAYS_W-1:0] day_count;
  hms_t              day_hms;
  logic              day_ok;

  logic [SEC_W-1:0]  secs;
  logic              res_ok;

  cte_decode #(
    .YEAR_BITS (YEAR_BITS),
    .YEAR_W    (YEAR_W)
  ) u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .yoff_i      (yoff),
    .month_i     (month),
    .day_i       (day),
    .hms_i       (hms_in),
    .out_valid_o (dec_valid),
    .out_ready_i (dec_ready),
    .year_o      (dec_year),
    .month_o     (dec_month),
    .day_o       (dec_day),
    .hms_o       (dec_hms),
    .q_year_o    (dec_qy),
    .q_prev_o    (dec_qp),
    .chk_o       (dec_chk)
  );

  cte_days #(
    .YEAR_W (YEAR_W),
    .DAYS_W (DAYS_W)
  ) u_days (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dec_valid),
    .in_ready_o  (dec_ready),
    .year_i      (dec_year),
    .month_i     (dec_month),
    .day_i       (dec_day),
    .hms_i       (dec_hms),
    .q_year_i    (dec_qy),
    .q_prev_i    (dec_qp),
    .chk_i       (dec_chk),
    .out_valid_o (day_valid),
    .out_ready_i (day_ready),
    .days_o      (day_count),
    .hms_o       (day_hms),
    .ok_o        (day_ok)
  );

  cte_scale #(
    .DAYS_W (DAYS_W)
  ) u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (day_valid),
    .in_ready_o  (day_ready),
    .days_i      (day_count),
    .hms_i       (day_hms),
    .ok_i        (day_ok),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .secs_o      (secs),
    .ok_o        (res_ok)
  );

  assign m_axis_tdata = OUT_W'(secs);
  assign m_axis_tuser = res_ok;

  // items in flight, for checking only
  logic [OCC_W-1:0] occ_q, occ_d;
  logic             in_xfer, out_xfer;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;
  assign occ_d    = occ_q + OCC_W'(in_xfer) - OCC_W'(out_xfer);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  a_rejected_is_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("invalid result with nonzero seconds");

  a_occ_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(PIPE_DEPTH))
    else $error("more items in flight than pipeline stages");

  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready && occ_q == OCC_W'(PIPE_DEPTH))
    else $error("input stalled with room in the pipeline");

  a_out_has_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> occ_q != '0)
    else $error("result presented with nothing in flight");

endmodule
`default_nettype wire

@@ sim/calendar_to_epoch_seconds_tb.sv @@
// Self-checking testbench for the calendar date and time to epoch seconds converter.
`timescale 1ns / 1ps
module calendar_to_epoch_seconds_tb;
  import cte_pkg::*;

  localparam int unsigned IN_W  = 40;   // 34 bits of fields, zero padded
  localparam int unsigned OUT_W = ((SEC_W + 7) / 8) * 8;
  localparam int unsigned N_RAND      = 1625;
  localparam int unsigned PHASE_A_END = 550;   // sender 18 %, receiver 49 % idle
  localparam int unsigned PHASE_B_END = 1100;  // sender 49 %, receiver 18 % idle
  localparam int unsigned HOLD_AT     = 1300;  // receiver back-pressure point
  localparam int unsigned HOLD_LEN    = 60;
  localparam int unsigned DRAIN_MAX   = 2000;

  // common-year tables, Jan first
  localparam int unsigned MLEN[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int unsigned DAYS_AHEAD[12] =
    '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  // fields of one input transfer, year in the lowest bits
  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] mday;
    logic [3:0] month;
    logic [7:0] year;
  } cal_t;

  typedef struct packed {
    logic [SEC_W-1:0] secs;
    logic             ok;
  } stamp_t;

  logic             clk_i  = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic [0:0]       m_tuser;

  logic [IN_W-1:0] cal_queue[$];
  stamp_t          stamp_queue[$];
  int unsigned     n_in = 0;
  int unsigned     n_err = 0;
  int unsigned     tx_idle_pct;
  int unsigned     rx_idle_pct;
  int unsigned     hold_cnt = 0;
  logic            hold_done = 1'b0;

  always #5 clk_i = ~clk_i;

  calendar_to_epoch_seconds u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser)
  );

  function automatic logic is_leap(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned leaps_upto(input int unsigned y);
    return y / 4 - y / 100 + y / 400;
  endfunction

  function automatic int unsigned days_in(input int unsigned y, input int unsigned mon);
    return MLEN[mon] + ((mon == 1 && is_leap(y)) ? 1 : 0);
  endfunction

  function automatic logic [IN_W-1:0] pack(input int unsigned y, input int unsigned mon,
                                           input int unsigned d, input int unsigned h,
                                           input int unsigned mi, input int unsigned s);
    cal_t c;
    c.year   = y[7:0];
    c.month  = mon[3:0];
    c.mday   = d[4:0];
    c.hour   = h[4:0];
    c.minute = mi[5:0];
    c.second = s[5:0];
    return {{(IN_W - $bits(cal_t)){1'b0}}, c};
  endfunction

  // expected seconds and valid flag for one calendar transfer
  function automatic stamp_t epoch_of(input cal_t c);
    stamp_t           r;
    int unsigned      y;
    longint unsigned  days;
    longint unsigned  secs;
    logic             good;
    y    = BASE_YEAR + c.year;
    good = (c.year >= EPOCH_OFS) && (c.month <= 11) && (c.hour <= 23) &&
           (c.minute <= 59) && (c.second <= 59);
    if (good) good = (c.mday >= 1) && (c.mday <= days_in(y, c.month));
    if (!good) begin
      r.secs = '0;
      r.ok   = 1'b0;
      return r;
    end
    days = longint'(y - EPOCH_YEAR) * 365 + (leaps_upto(y - 1) - leaps_upto(EPOCH_YEAR - 1));
    days += DAYS_AHEAD[c.month];
    if (c.month > 1 && is_leap(y)) days += 1;
    days += c.mday - 1;
    secs = ((days * 24 + c.hour) * 60 + c.minute) * 60 + c.second;
    r.secs = secs[SEC_W-1:0];
    r.ok   = 1'b1;
    return r;
  endfunction

  // well-formed date and time, random content
  function automatic logic [IN_W-1:0] good_item();
    int unsigned y;
    int unsigned mon;
    y   = $urandom_range(255, EPOCH_OFS);
    mon = $urandom_range(11);
    return pack(y, mon, $urandom_range(days_in(BASE_YEAR + y, mon), 1), $urandom_range(23),
                $urandom_range(59), $urandom_range(59));
  endfunction

  // idle rates per phase, by transfers accepted so far
  always_comb begin
    if (n_in < PHASE_A_END) begin
      tx_idle_pct = 18;
      rx_idle_pct = 49;
    end else if (n_in < PHASE_B_END) begin
      tx_idle_pct = 49;
      rx_idle_pct = 18;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  end

  // sender: next pending item once the current one is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else if (!s_tvalid || s_tready) begin
      if (cal_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata  <= cal_queue.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off to fill the pipeline
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      m_tready <= 1'b0;
    end else if (!hold_done && n_in >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_cnt  <= HOLD_LEN;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // check results against the oldest expectation, then record new inputs
  always @(posedge clk_i) begin : mon
    stamp_t want;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        if (stamp_queue.size() == 0) begin
          $error("unexpected result: epoch_seconds %0d valid_res %0d",
                 m_tdata[SEC_W-1:0], m_tuser[0]);
          n_err++;
        end else begin
          want = stamp_queue.pop_front();
          if (m_tdata[SEC_W-1:0] !== want.secs) begin
            $error("epoch_seconds: expected %0d, got %0d", want.secs, m_tdata[SEC_W-1:0]);
            n_err++;
          end
          if (m_tuser[0] !== want.ok) begin
            $error("valid_res: expected %0d, got %0d", want.ok, m_tuser[0]);
            n_err++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        stamp_queue.push_back(epoch_of(cal_t'(s_tdata[$bits(cal_t)-1:0])));
        n_in <= n_in + 1;
      end
    end
  end

  initial begin : main
    int unsigned waited;
    int unsigned pick;
    logic [IN_W-1:0] w;
    cal_t c;

    // directed: epoch, extremes, leap rule, each range check
    cal_queue.push_back(pack(70, 0, 1, 0, 0, 0));
    cal_queue.push_back(pack(255, 11, 31, 23, 59, 59));
    cal_queue.push_back(pack(69, 11, 31, 23, 59, 59));
    cal_queue.push_back(pack(0, 0, 1, 0, 0, 0));
    cal_queue.push_back(pack(100, 1, 29, 12, 0, 0));    // 2000 is a leap year
    cal_queue.push_back(pack(200, 1, 29, 12, 0, 0));    // 2100 is not
    cal_queue.push_back(pack(204, 1, 29, 12, 0, 0));    // 2104 is
    cal_queue.push_back(pack(71, 1, 29, 0, 0, 0));
    cal_queue.push_back(pack(71, 1, 28, 0, 0, 0));
    cal_queue.push_back(pack(80, 12, 1, 0, 0, 0));
    cal_queue.push_back(pack(80, 15, 1, 0, 0, 0));
    cal_queue.push_back(pack(80, 5, 0, 0, 0, 0));
    cal_queue.push_back(pack(80, 3, 31, 0, 0, 0));
    cal_queue.push_back(pack(80, 3, 30, 0, 0, 0));
    cal_queue.push_back(pack(90, 6, 15, 24, 0, 0));
    cal_queue.push_back(pack(90, 6, 15, 31, 0, 0));
    cal_queue.push_back(pack(90, 6, 15, 10, 60, 0));
    cal_queue.push_back(pack(90, 6, 15, 10, 63, 0));
    cal_queue.push_back(pack(90, 6, 15, 10, 30, 60));
    cal_queue.push_back(pack(90, 6, 15, 10, 30, 63));
    cal_queue.push_back(pack(255, 15, 31, 31, 63, 63));
    cal_queue.push_back(pack(100, 2, 1, 0, 0, 0));      // leap day counted after February
    cal_queue.push_back(pack(72, 11, 31, 23, 59, 59));

    // random: mostly valid dates, some with one field broken, some raw noise
    for (int unsigned i = 0; i < N_RAND; i++) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        w = good_item();
      end else if (pick < 80) begin
        w = good_item();
        c = cal_t'(w[$bits(cal_t)-1:0]);
        case ($urandom_range(5))
          0: c.year   = 8'($urandom_range(EPOCH_OFS - 1));
          1: c.month  = 4'($urandom_range(15, 12));
          2: c.mday   = ($urandom_range(1) != 0) ? 5'd0 : 5'(days_in(BASE_YEAR + c.year,
                                                                      c.month) + 1);
          3: c.hour   = 5'($urandom_range(31, 24));
          4: c.minute = 6'($urandom_range(63, 60));
          default: c.second = 6'($urandom_range(63, 60));
        endcase
        if (c.mday > 31) c.mday = 5'd0;
        w = {{(IN_W - $bits(cal_t)){1'b0}}, c};
      end else begin
        w = {{(IN_W - $bits(cal_t)){1'b0}}, $urandom(), 2'($urandom())};
      end
      cal_queue.push_back(w);
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cal_queue.size() != 0 || s_tvalid) @(posedge clk_i);
    waited = 0;
    while (stamp_queue.size() != 0 && waited < DRAIN_MAX) begin
      @(posedge clk_i);
      waited++;
    end
    if (stamp_queue.size() != 0) begin
      $error("%0d results never arrived", stamp_queue.size());
      n_err++;
    end
    // pipeline is 5 deep; leave room for any stray output
    repeat (20) @(posedge clk_i);

    if (n_err == 0) begin
      $display("** calendar_to_epoch_seconds: PASSED **");
    end else begin
      $display("** calendar_to_epoch_seconds: FAILED **");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("** calendar_to_epoch_seconds: FAILED **");
    $finish;
  end

endmodule
